/* design/assert_macros.svh */
// Assertion macros shared by the thrust curve interpolator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check an implication-style property on every rising edge outside reset.
`define TCI_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition never holds outside reset.
`define TCI_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TCI_ASSERT(lbl, clk, rst_n, prop, msg)
`define TCI_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

/* design/tci_pkg.sv */
// Types, codes and command/status structs of the thrust curve interpolator.
package tci_pkg;

	localparam int TIME_W   = 32;
	localparam int FORCE_W  = 32;
	localparam int NOW_W    = 40;
	localparam int CNT_W    = 7;
	localparam int SLOT_W   = 6;
	localparam int ENTRY_W  = TIME_W + FORCE_W;
	localparam int DIV_STEPS = 32;
	localparam int DIV_CNT_W = 5;

	// Request function codes
	localparam logic [1:0] FN_WRITE    = 2'd0;
	localparam logic [1:0] FN_ACTIVATE = 2'd1;
	localparam logic [1:0] FN_QUERY    = 2'd2;

	// Result region codes
	localparam logic [1:0] RG_INACTIVE = 2'd0;
	localparam logic [1:0] RG_BEFORE   = 2'd1;
	localparam logic [1:0] RG_INTERP   = 2'd2;
	localparam logic [1:0] RG_AFTER    = 2'd3;

	// Table read address select
	localparam logic [1:0] RD_ZERO = 2'd0;
	localparam logic [1:0] RD_LAST = 2'd1;
	localparam logic [1:0] RD_ONE  = 2'd2;
	localparam logic [1:0] RD_NEXT = 2'd3;

	typedef struct packed {
		logic [1:0]          func;
		logic [SLOT_W-1:0]   point_index;
		logic [TIME_W-1:0]   point_time_us;
		logic signed [FORCE_W-1:0] point_force;
		logic [NOW_W-1:0]    now_us;
	} in_t;

	typedef struct packed {
		logic signed [FORCE_W-1:0] force_res;
		logic [1:0]                region;
	} out_t;

	typedef struct packed {
		logic       accept;
		logic [1:0] rd_sel;
		logic       ld_prev;
		logic       ld_cur;
		logic       idx_one;
		logic       idx_inc;
		logic       ld_diff;
		logic       ld_prod;
		logic       div_run;
		logic       res_load;
		logic [1:0] res_region;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic ignited;
		logic le_first;
		logic ge_last;
		logic srch_stop;
		logic div_done;
		logic out_free;
	} sts_t;

endpackage

/* design/thrust_curve_interpolator_top.sv */
// Top level of the thrust curve interpolator: controller plus datapath.
//
// Piecewise-linear thrust curve lookup. A request either writes one
// (time, force) point into a table of MAX_POINTS slots, activates the motor
// (only the first activate latches the ignition time), or queries the thrust
// at now_us. A query returns one result: zero while inactive, the first force
// before or at the first point, the last force at or after the last point in
// use, and otherwise f0 + (f1 - f0) * (e - t0) / (t1 - t0) truncated toward
// zero across the segment that holds the elapsed time e. Write and activate
// requests return nothing. How long an interpolated query takes is set by
// the linear search through the single read port of the point table and by
// the bit-serial divider. One request is in work at a time; a finished
// result waits in the output register and the next request may be taken
// while it waits. The table needs no clearing after reset; a query that
// touches a slot never written returns undefined data. point_count is to
// be written through cfg_we/cfg_wdata only while the block is idle, which
// the block itself does not enforce; 0 counts as one point and values
// above MAX_POINTS count as MAX_POINTS.
module thrust_curve_interpolator_top import tci_pkg::*; #(
	parameter int MAX_POINTS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	// request channel
	input  logic             in_valid,
	output logic             in_ready,
	input  in_t              in_data,
	// result channel
	output logic             out_valid,
	input  logic             out_ready,
	output out_t             out_data,
	// point count register
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata
);

	// Commands from the sequencer, status back from the datapath
	cmd_t cmd;
	sts_t sts;

	// Sequence each request: search, multiply, divide, hand off the result
	tci_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_func (in_data.func),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	// Hold the table, ignition state, arithmetic and the output register
	tci_dp #(
		.MAX_POINTS(MAX_POINTS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.cmd      (cmd),
		.sts      (sts),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule

/* design/tci_ram.sv */
// Generic single write port, single registered read port RAM.
module tci_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_q <= mem_q[raddr];
	end

	assign rdata = rd_q;

endmodule

/* design/tci_ctrl.sv */
// Controller state machine sequencing each request through the datapath.
`include "assert_macros.svh"

module tci_ctrl import tci_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] in_func,
	output logic       in_ready,
	input  sts_t       sts,
	output cmd_t       cmd
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CHK0 = 4'd1;
	localparam logic [3:0] S_CHKL = 4'd2;
	localparam logic [3:0] S_SRCH = 4'd3;
	localparam logic [3:0] S_MUL1 = 4'd4;
	localparam logic [3:0] S_MUL2 = 4'd5;
	localparam logic [3:0] S_DIV  = 4'd6;
	localparam logic [3:0] S_FIN  = 4'd7;
	localparam logic [3:0] S_DONE = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.rd_sel = RD_ZERO;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (in_func == FN_QUERY) begin
						if (sts.ignited) begin
							state_d = S_CHK0;
						end else begin
							cmd.res_load = 1'b1;
							cmd.res_region = RG_INACTIVE;
							state_d = S_DONE;
						end
					end
				end
			end
			S_CHK0: begin
				cmd.ld_prev = 1'b1;
				if (sts.le_first) begin
					cmd.res_load = 1'b1;
					cmd.res_region = RG_BEFORE;
					state_d = S_DONE;
				end else begin
					cmd.rd_sel = RD_LAST;
					state_d = S_CHKL;
				end
			end
			S_CHKL: begin
				if (sts.ge_last) begin
					cmd.res_load = 1'b1;
					cmd.res_region = RG_AFTER;
					state_d = S_DONE;
				end else begin
					cmd.idx_one = 1'b1;
					cmd.rd_sel = RD_ONE;
					state_d = S_SRCH;
				end
			end
			S_SRCH: begin
				if (sts.srch_stop) begin
					cmd.ld_cur = 1'b1;
					state_d = S_MUL1;
				end else begin
					cmd.ld_prev = 1'b1;
					cmd.idx_inc = 1'b1;
					cmd.rd_sel = RD_NEXT;
				end
			end
			S_MUL1: begin
				cmd.ld_diff = 1'b1;
				state_d = S_MUL2;
			end
			S_MUL2: begin
				cmd.ld_prod = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div_run = 1'b1;
				if (sts.div_done) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				cmd.res_load = 1'b1;
				cmd.res_region = RG_INTERP;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`TCI_ASSERT(a_out_load_free, clk, arst_n, cmd.out_load |-> sts.out_free, "output overwritten")
	`TCI_ASSERT(a_fin_after_div, clk, arst_n, (state_q == S_FIN) |-> ($past(state_q) == S_DIV), "finish without divide")
	`TCI_ASSERT_NEVER(a_accept_busy, clk, arst_n, cmd.accept && (cmd.res_load && cmd.res_region != RG_INACTIVE), "busy accept")

endmodule

/* design/tci_dp.sv */
// Datapath: point table, ignition state, search registers, multiplier and divider.
`include "assert_macros.svh"

module tci_dp import tci_pkg::*; #(
	parameter int MAX_POINTS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  in_t              in_data,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	input  cmd_t             cmd,
	output sts_t             sts,
	output logic             out_valid,
	input  logic             out_ready,
	output out_t             out_data
);

	localparam int AW = $clog2(MAX_POINTS);

	logic [CNT_W-1:0]  count_q;
	logic              ignited_q;
	logic [NOW_W-1:0]  ign_time_q;
	logic              before_q;
	logic [NOW_W-1:0]  e_q;
	logic [AW-1:0]     idx_q;
	logic [TIME_W-1:0] prev_time_q;
	logic [FORCE_W-1:0] prev_force_q;
	logic [TIME_W-1:0] cur_time_q;
	logic [FORCE_W-1:0] cur_force_q;
	logic [31:0]       mag_q;
	logic [31:0]       d_q;
	logic [31:0]       den_q;
	logic              neg_q;
	logic [31:0]       rem_q;
	logic [31:0]       quo_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [FORCE_W-1:0] res_force_q;
	logic [1:0]        res_region_q;
	logic              out_valid_q;
	out_t              out_data_q;

	logic [31:0]       cnt32_w;
	logic [31:0]       n_w;
	logic [AW-1:0]     last_w;
	logic [AW-1:0]     rd_addr_w;
	logic              wr_en_w;
	logic [ENTRY_W-1:0] rd_entry_w;
	logic [TIME_W-1:0] rd_time_w;
	logic [FORCE_W-1:0] rd_force_w;
	logic [NOW_W:0]    elapsed_w;
	logic [32:0]       df_w;
	logic [32:0]       neg_df_w;
	logic [63:0]       prod_w;
	logic [32:0]       dtmp_w;
	logic [32:0]       dsub_w;
	logic              dge_w;
	logic [32:0]       interp_w;
	logic [FORCE_W-1:0] res_force_w;

	// Points in use, clamped to one and to the table depth
	assign cnt32_w = 32'(count_q);
	assign n_w = (count_q == '0) ? 32'd1 :
		((cnt32_w > 32'(MAX_POINTS)) ? 32'(MAX_POINTS) : cnt32_w);
	assign last_w = AW'(n_w - 32'd1);

	assign wr_en_w = cmd.accept && (in_data.func == FN_WRITE) &&
		(32'(in_data.point_index) < 32'(MAX_POINTS));

	always_comb begin
		case (cmd.rd_sel)
			RD_ZERO: rd_addr_w = '0;
			RD_LAST: rd_addr_w = last_w;
			RD_ONE:  rd_addr_w = AW'(1);
			RD_NEXT: rd_addr_w = idx_q + AW'(1);
			default: rd_addr_w = '0;
		endcase
	end

	tci_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_POINTS)
	) u_table (
		.clk  (clk),
		.we   (wr_en_w),
		.waddr(AW'(in_data.point_index)),
		.wdata({in_data.point_time_us, in_data.point_force}),
		.raddr(rd_addr_w),
		.rdata(rd_entry_w)
	);

	assign rd_time_w  = rd_entry_w[ENTRY_W-1:FORCE_W];
	assign rd_force_w = rd_entry_w[FORCE_W-1:0];

	assign elapsed_w = {1'b0, in_data.now_us} - {1'b0, ign_time_q};

	// Segment arithmetic; elapsed lies strictly above t0 and at most t1 here
	assign df_w     = {cur_force_q[FORCE_W-1], cur_force_q} -
		{prev_force_q[FORCE_W-1], prev_force_q};
	assign neg_df_w = 33'd0 - df_w;
	assign prod_w   = 64'(mag_q) * 64'(d_q);

	// One restoring divide step per cycle
	assign dtmp_w = {rem_q, quo_q[31]};
	assign dge_w  = dtmp_w >= {1'b0, den_q};
	assign dsub_w = dtmp_w - {1'b0, den_q};

	assign interp_w = neg_q ?
		({prev_force_q[FORCE_W-1], prev_force_q} - {1'b0, quo_q}) :
		({prev_force_q[FORCE_W-1], prev_force_q} + {1'b0, quo_q});

	always_comb begin
		case (cmd.res_region)
			RG_INACTIVE: res_force_w = '0;
			RG_BEFORE:   res_force_w = rd_force_w;
			RG_INTERP:   res_force_w = interp_w[FORCE_W-1:0];
			RG_AFTER:    res_force_w = rd_force_w;
			default:     res_force_w = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= CNT_W'(1);
			ignited_q   <= 1'b0;
			ign_time_q  <= '0;
			idx_q       <= '0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				count_q <= cfg_wdata;
			end
			if (cmd.accept && (in_data.func == FN_ACTIVATE) && !ignited_q) begin
				ignited_q  <= 1'b1;
				ign_time_q <= in_data.now_us;
			end
			if (cmd.idx_one) begin
				idx_q <= AW'(1);
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + AW'(1);
			end
			if (cmd.ld_prod) begin
				div_cnt_q <= '0;
			end else if (cmd.div_run) begin
				div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			before_q <= elapsed_w[NOW_W];
			e_q      <= elapsed_w[NOW_W-1:0];
		end
		if (cmd.ld_prev) begin
			prev_time_q  <= rd_time_w;
			prev_force_q <= rd_force_w;
		end
		if (cmd.ld_cur) begin
			cur_time_q  <= rd_time_w;
			cur_force_q <= rd_force_w;
		end
		if (cmd.ld_diff) begin
			neg_q <= df_w[32];
			mag_q <= df_w[32] ? neg_df_w[31:0] : df_w[31:0];
			d_q   <= e_q[31:0] - prev_time_q;
			den_q <= cur_time_q - prev_time_q;
		end
		if (cmd.ld_prod) begin
			rem_q <= prod_w[63:32];
			quo_q <= prod_w[31:0];
		end else if (cmd.div_run) begin
			rem_q <= dge_w ? dsub_w[31:0] : dtmp_w[31:0];
			quo_q <= {quo_q[30:0], dge_w};
		end
		if (cmd.res_load) begin
			res_force_q  <= res_force_w;
			res_region_q <= cmd.res_region;
		end
		if (cmd.out_load) begin
			out_data_q.force_res <= res_force_q;
			out_data_q.region    <= res_region_q;
		end
	end

	assign sts.ignited   = ignited_q;
	assign sts.le_first  = before_q || (e_q <= NOW_W'(rd_time_w));
	assign sts.ge_last   = e_q >= NOW_W'(rd_time_w);
	assign sts.srch_stop = (idx_q == last_w) || (NOW_W'(rd_time_w) >= e_q);
	assign sts.div_done  = (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
	assign sts.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`TCI_ASSERT(a_idx_in_span, clk, arst_n, cmd.idx_inc |-> (idx_q < last_w), "search ran past last point")
	`TCI_ASSERT(a_quot_fits, clk, arst_n, cmd.ld_prod |=> (rem_q < den_q), "quotient exceeds 32 bits")
	`TCI_ASSERT(a_div_rem, clk, arst_n, (cmd.div_run && $past(cmd.div_run)) |-> (rem_q < den_q), "divider remainder out of range")

endmodule

/* tb/tb_thrust_curve_interpolator_top.sv */
// Self-checking testbench for the thrust curve interpolator top level.
module tb_thrust_curve_interpolator_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tci_pkg::*;

	localparam int MAX_POINTS = 64;
	// Quiet time after the last answer, sized for the longest query plus margin.
	localparam int DRAIN_CYCLES = 39 + MAX_POINTS + 8;
	localparam int PHASES = 16;
	localparam int PHASE_ITEMS = 68;
	// Ignition time latched by the one activate that counts.
	localparam logic [NOW_W-1:0] IGNITE_US = 40'd1000;
	// Function code the block leaves unused.
	localparam logic [1:0] FN_UNUSED = 2'd3;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	// Predicts the thrust answer of every query and holds the answers until
	// the block returns them, oldest first.
	class thrust_scoreboard_t;
		logic [TIME_W-1:0]         curve_times [MAX_POINTS];
		logic signed [FORCE_W-1:0] curve_forces [MAX_POINTS];
		bit                        ignited;
		logic [NOW_W-1:0]          ignition_time;
		logic [CNT_W-1:0]          point_count;
		out_t                      expected_thrust [$];
		int unsigned               errors;
		int unsigned               checked;
		int unsigned               region_seen [4];

		function new();
			ignited = 1'b0;
			ignition_time = '0;
			point_count = CNT_W'(1);
			errors = 0;
			checked = 0;
			foreach (region_seen[r]) region_seen[r] = 0;
		endfunction

		// Zero counts as one point, anything past the table as a full table.
		function int unsigned points_in_use();
			if (point_count == 0) return 1;
			if (point_count > MAX_POINTS) return MAX_POINTS;
			return point_count;
		endfunction

		// Linear step from slot i-1 toward slot i, quotient truncated toward zero.
		function logic [FORCE_W-1:0] lerp(int unsigned i, logic [TIME_W-1:0] e);
			longint f0, f1, df, res;
			logic [63:0] mag, num, den, q;
			f0 = curve_forces[i-1];
			f1 = curve_forces[i];
			df = f1 - f0;
			mag = (df < 0) ? 64'(-df) : 64'(df);
			num = mag * 64'(e - curve_times[i-1]);
			den = 64'(curve_times[i] - curve_times[i-1]);
			q = num / den;
			res = (df < 0) ? f0 - longint'(q) : f0 + longint'(q);
			return FORCE_W'(res);
		endfunction

		function out_t thrust_at(logic [NOW_W-1:0] now);
			int unsigned last, i;
			logic [NOW_W-1:0] e;
			out_t r;
			last = points_in_use() - 1;
			e = now - ignition_time;
			if (!ignited) begin
				r.force_res = '0;
				r.region = RG_INACTIVE;
			end else if (now < ignition_time || e <= NOW_W'(curve_times[0])) begin
				r.force_res = curve_forces[0];
				r.region = RG_BEFORE;
			end else if (e >= NOW_W'(curve_times[last])) begin
				r.force_res = curve_forces[last];
				r.region = RG_AFTER;
			end else begin
				i = 1;
				while (i < last && NOW_W'(curve_times[i]) < e) i++;
				r.force_res = lerp(i, e[TIME_W-1:0]);
				r.region = RG_INTERP;
			end
			return r;
		endfunction

		function void note_request(in_t req);
			case (req.func)
				FN_WRITE: begin
					curve_times[req.point_index] = req.point_time_us;
					curve_forces[req.point_index] = req.point_force;
				end
				FN_ACTIVATE: begin
					if (!ignited) begin
						ignited = 1'b1;
						ignition_time = req.now_us;
					end
				end
				FN_QUERY: expected_thrust = {expected_thrust, thrust_at(req.now_us)};
				default: ;
			endcase
		endfunction

		function void check_result(out_t got);
			out_t want;
			if (expected_thrust.size() == 0) begin
				$display("%0t: unexpected result: force_res %0d region %0d",
					$time, got.force_res, got.region);
				errors++;
				return;
			end
			want = expected_thrust.pop_front();
			checked++;
			region_seen[want.region]++;
			if (got.force_res !== want.force_res) begin
				$display("%0t: force_res mismatch: expected %0d, actual %0d",
					$time, want.force_res, got.force_res);
				errors++;
			end
			if (got.region !== want.region) begin
				$display("%0t: region mismatch: expected %0d, actual %0d",
					$time, want.region, got.region);
				errors++;
			end
		endfunction

		function void close_out();
			foreach (expected_thrust[k]) begin
				$display("%0t: missing result: expected force_res %0d region %0d",
					$time, expected_thrust[k].force_res, expected_thrust[k].region);
				errors++;
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	in_t              in_data = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	out_t             out_data;
	logic             cfg_we = 1'b0;
	logic [CNT_W-1:0] cfg_wdata = '0;

	thrust_scoreboard_t board = new();

	// Stimulus-side view of the table: which slots hold a point, and at what time.
	// Queries never run until every slot in use has been written.
	logic [TIME_W-1:0] slot_time [MAX_POINTS];
	bit                slot_written [MAX_POINTS];

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned settings = 0;

	thrust_curve_interpolator_top #(.MAX_POINTS(MAX_POINTS)) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result side: check what was taken at this edge, then pick the next ready.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) board.check_result(out_data);
		out_ready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
	end

	// Hard stop in case the block hangs; a correct run ends far earlier.
	initial begin
		#20ms;
		$display("%0t: timeout with %0d results outstanding", $time,
			board.expected_thrust.size());
		$display("Some tests failed");
		$finish;
	end

	function automatic logic [NOW_W-1:0] rand_now();
		return {8'($urandom), 32'($urandom)};
	endfunction

	// Pick a query time that lands before, on, between or past the points.
	function automatic logic [NOW_W-1:0] pick_query_time(int unsigned n);
		int unsigned last, k, pick;
		logic [TIME_W-1:0] lo, hi;
		logic [NOW_W-1:0] e;
		last = n - 1;
		pick = $urandom_range(99);
		if (pick < 8) return rand_now();
		if (pick < 18) begin
			e = NOW_W'($urandom_range(slot_time[0], 0));
		end else if (pick < 28 || last == 0) begin
			e = NOW_W'(slot_time[last]) + NOW_W'($urandom_range(2, 0));
		end else if (pick < 40) begin
			e = NOW_W'(slot_time[$urandom_range(last, 0)]);
		end else begin
			k = $urandom_range(last, 1);
			lo = slot_time[k-1];
			hi = slot_time[k];
			if (lo > hi) begin
				lo = slot_time[k];
				hi = slot_time[k-1];
			end
			e = NOW_W'($urandom_range(hi, lo));
		end
		return IGNITE_US + e;
	endfunction

	// Present one request and hold it until the block takes it.
	task automatic issue(input logic [1:0] fn, input logic [SLOT_W-1:0] slot,
			input logic [TIME_W-1:0] t, input logic [FORCE_W-1:0] f,
			input logic [NOW_W-1:0] now);
		in_t req;
		req = '{func: fn, point_index: slot, point_time_us: t, point_force: f, now_us: now};
		if (fn == FN_WRITE) begin
			slot_time[slot] = t;
			slot_written[slot] = 1'b1;
		end
		// Drop valid for a random gap; valid stays up across back-to-back requests.
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		in_data <= req;
		do @(posedge clk); while (!in_ready);
		board.note_request(req);
	endtask

	task automatic write_point(input logic [SLOT_W-1:0] slot, input logic [TIME_W-1:0] t,
			input logic [FORCE_W-1:0] f);
		issue(FN_WRITE, slot, t, f, rand_now());
	endtask

	task automatic activate(input logic [NOW_W-1:0] now);
		issue(FN_ACTIVATE, SLOT_W'($urandom), $urandom, $urandom, now);
	endtask

	task automatic query_force(input logic [NOW_W-1:0] now);
		int unsigned n;
		n = board.points_in_use();
		// Fill any slot in use that was never written, keeping time order.
		for (int unsigned s = 0; s < n; s++)
			if (!slot_written[s])
				write_point(SLOT_W'(s), (s == 0) ? '0 : slot_time[s-1], $urandom);
		issue(FN_QUERY, SLOT_W'($urandom), $urandom, $urandom, now);
	endtask

	// Write n points: mostly in time order over a wide or a narrow span
	// (narrow spans repeat times), now and then in random order.
	task automatic build_curve(input int unsigned n);
		int unsigned style;
		logic [TIME_W-1:0] t, span;
		style = $urandom_range(5);
		span = (style <= 1) ? 32'hFFFF_FFFF / n : 32'd60;
		t = $urandom_range(span, 0);
		for (int unsigned s = 0; s < n; s++) begin
			if (style == 5) t = $urandom;
			write_point(SLOT_W'(s), t, $urandom);
			t = t + $urandom_range(span, 0);
		end
	endtask

	// Hold off until every answer is back and the block has gone quiet.
	task automatic settle();
		in_valid <= 1'b0;
		while (board.expected_thrust.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_point_count(input logic [CNT_W-1:0] v);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.point_count = v;
		settings++;
	endtask

	task automatic set_idling(input idle_mode_t mode);
		send_idle_pct = (mode == IDLE_SENDER) ? 86 : (mode == IDLE_BOTH) ? 29 : 0;
		recv_stall_pct = (mode == IDLE_RECEIVER) ? 86 : (mode == IDLE_BOTH) ? 29 : 0;
	endtask

	initial begin
		int unsigned counted, n, pick;
		logic [CNT_W-1:0] pc;
		logic [SLOT_W-1:0] slot;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: a four point curve with extreme forces and times.
		set_point_count(CNT_W'(4));
		write_point(6'd0, 32'd100, 32'h7FFF_FFFF);
		write_point(6'd1, 32'd1000, 32'h8000_0000);
		write_point(6'd2, 32'd2000, 32'h0000_0000);
		write_point(6'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		write_point(6'd63, 32'd0, 32'd0);
		// The unused function code must change nothing and answer nothing.
		issue(FN_UNUSED, SLOT_W'($urandom), $urandom, $urandom, rand_now());
		// Queries before ignition answer zero.
		query_force('0);
		query_force('1);
		activate(IGNITE_US);
		// A second activate must not move the ignition time.
		activate(rand_now());
		query_force('0);                        // earlier than ignition
		query_force(IGNITE_US);                 // zero elapsed
		query_force(IGNITE_US + 40'd100);       // on the first point
		query_force(IGNITE_US + 40'd101);       // just past it, steep fall
		query_force(IGNITE_US + 40'd1000);      // on a segment end
		query_force(IGNITE_US + 40'd1500);      // rising segment
		query_force(IGNITE_US + 40'hFFFF_FFFF); // on the last point
		query_force('1);                        // far past the last point
		// Break time order and search through it.
		write_point(6'd2, 32'd50, 32'h04D2_0000);
		query_force(IGNITE_US + 40'd1500);
		query_force(IGNITE_US + 40'hFFFF_FFFE);

		// Random part: one point count and one idling pattern per phase.
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: pc = CNT_W'(0);
				1: pc = CNT_W'(127);
				2: pc = CNT_W'(64);
				3: pc = CNT_W'(1);
				4: pc = CNT_W'(65);
				default: pc = ($urandom_range(5) == 0) ? CNT_W'($urandom_range(127))
					: CNT_W'($urandom_range(12, 2));
			endcase
			set_point_count(pc);
			set_idling(idle_mode_t'(phase % 4));
			n = board.points_in_use();
			if (phase < 5 || $urandom_range(3) != 0) build_curve(n);
			counted = 0;
			while (counted < PHASE_ITEMS) begin
				pick = $urandom_range(99);
				if (pick < 72) begin
					query_force(pick_query_time(n));
				end else if (pick < 84) begin
					// Mostly retune a force in place; sometimes move the point too.
					slot = SLOT_W'($urandom_range(MAX_POINTS - 1));
					if (slot_written[slot] && $urandom_range(3) != 0)
						write_point(slot, slot_time[slot], $urandom);
					else
						write_point(slot, $urandom, $urandom);
				end else if (pick < 92) begin
					activate(rand_now());
				end else begin
					issue(FN_UNUSED, SLOT_W'($urandom), $urandom, $urandom, rand_now());
				end
				counted++;
			end
		end

		settle();
		board.close_out();
		$display("Checked %0d thrust answers across %0d point count settings, four idling patterns",
			board.checked, settings);
		$display("Regions: inactive %0d, before first %0d, interpolated %0d, after last %0d",
			board.region_seen[RG_INACTIVE], board.region_seen[RG_BEFORE],
			board.region_seen[RG_INTERP], board.region_seen[RG_AFTER]);
		if (board.errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
